/* rtl/dmacr_pkg.sv */
// Types, codes and decode helpers for the DMA channel register block.
// Used by the transfer datapath, the top level and the checker.
package dmacr_pkg;

    typedef enum logic [2:0] {
        CMD_PORT_READ  = 3'd0,
        CMD_PORT_WRITE = 3'd1,
        CMD_STEP       = 3'd2,
        CMD_ADVANCE    = 3'd3,
        CMD_REQUEST    = 3'd4
    } t_cmd;

    // Controller port addresses that need special handling.
    localparam logic [7:0] LAST_CHAN_PORT  = 8'h07;
    localparam logic [7:0] PORT_STATUS     = 8'h08;
    localparam logic [7:0] PORT_CLR_REQ    = 8'h09;
    localparam logic [7:0] PORT_MODE       = 8'h0B;
    localparam logic [7:0] PORT_CLR_BP     = 8'h0C;
    localparam logic [7:0] PORT_MASTER_CLR = 8'h0D;

    localparam logic [7:0]  STATUS_TC_KEEP = 8'hF0;
    localparam logic [15:0] CNT_WRAP       = 16'hFFFF;
    localparam logic [1:0]  SIZE_WORD      = 2'd2;

    // Bit of a mode-register write byte that enables autoinit.
    localparam int AUTOINIT_BIT = 4;
    // Bit of a request-clear write byte that suppresses the clear.
    localparam int CLR_REQ_SKIP_BIT = 2;

    typedef struct packed {
        logic [15:0] addr;
        logic [15:0] cnt;
        logic        set_tc;
    } t_xfer_res;

    function automatic logic is_page_port(input logic [7:0] p);
        return p inside {8'h81, 8'h82, 8'h83, 8'h87};
    endfunction

    function automatic logic is_spare_port(input logic [7:0] p);
        return p inside {8'h80, 8'h84, 8'h85, 8'h86, 8'h88, 8'h8C, 8'h8D, 8'h8E};
    endfunction

    // Page registers sit at scrambled port addresses.
    function automatic logic [1:0] page_chan(input logic [7:0] p);
        logic [1:0] c;
        case (p)
            8'h81:   c = 2'd2;
            8'h82:   c = 2'd3;
            8'h83:   c = 2'd1;
            default: c = 2'd0;
        endcase
        return c;
    endfunction

endpackage

/* rtl/dmacr_if.sv */
// Valid/ready channel interfaces for the DMA channel register block.
// Depends on nothing but carries the field widths of the request and response.
interface dmacr_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [7:0]  port;
    logic [15:0] write_data;
    logic [1:0]  access_size;
    logic [1:0]  channel;
    logic [15:0] advance;
    logic        request_level;

    modport source (output valid, command, port, write_data, access_size, channel,
                    advance, request_level, input ready);
    modport sink   (input valid, command, port, write_data, access_size, channel,
                    advance, request_level, output ready);
endinterface

interface dmacr_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic [23:0] full_address;
    logic [16:0] outstanding;
    logic        terminal_count;

    modport source (output valid, read_data, full_address, outstanding, terminal_count,
                    input ready);
    modport sink   (input valid, read_data, full_address, outstanding, terminal_count,
                    output ready);
endinterface

/* rtl/dma_controller_channel_registers.sv */
// Four-channel DMA controller register block: port access, transfers, request bits.
// A result is registered and presented in the cycle after its request transfer.
// Throughput: one request per clock; the single output register is the only stage,
// and a new request is taken whenever that register is empty or being drained.
// Reset (synchronous, active low) clears every channel, page and spare register,
// the status byte and the byte pointer, and empties the output register.
module dma_controller_channel_registers #(
    parameter int NUM_CHANNELS = 4,
    parameter int SPARE_DEPTH  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dmacr_req_if.sink   i_req,
    dmacr_rsp_if.source o_rsp
);
    import dmacr_pkg::*;

    localparam int CH_W = $clog2(NUM_CHANNELS);
    localparam int SP_W = $clog2(SPARE_DEPTH);

    logic [15:0] r_base_addr [NUM_CHANNELS];
    logic [15:0] n_base_addr [NUM_CHANNELS];
    logic [15:0] r_base_cnt  [NUM_CHANNELS];
    logic [15:0] n_base_cnt  [NUM_CHANNELS];
    logic [15:0] r_cur_addr  [NUM_CHANNELS];
    logic [15:0] n_cur_addr  [NUM_CHANNELS];
    logic [15:0] r_cur_cnt   [NUM_CHANNELS];
    logic [15:0] n_cur_cnt   [NUM_CHANNELS];
    logic [7:0]  r_page      [NUM_CHANNELS];
    logic [7:0]  n_page      [NUM_CHANNELS];
    logic [7:0]  r_spare     [SPARE_DEPTH];
    logic [7:0]  n_spare     [SPARE_DEPTH];
    logic [NUM_CHANNELS-1:0] r_autoinit;
    logic [NUM_CHANNELS-1:0] n_autoinit;
    logic        r_bp;
    logic        n_bp;
    logic [7:0]  r_status;
    logic [7:0]  n_status;

    logic        r_out_valid;
    logic [7:0]  r_read_data;
    logic [23:0] r_full_address;
    logic [16:0] r_outstanding;
    logic        r_terminal_count;

    logic            go;
    logic [CH_W-1:0] ch;
    logic [CH_W-1:0] pch;
    logic [CH_W-1:0] wch;
    logic [SP_W-1:0] sidx;
    logic [7:0]      wb;
    logic [15:0]     sel_word;
    logic            chan_port;
    logic [7:0]      n_rd;
    t_xfer_res       xres;

    assign go        = i_req.valid && i_req.ready;
    assign ch        = i_req.channel[CH_W-1:0];
    assign pch       = i_req.port[CH_W:1];
    assign wb        = i_req.write_data[7:0];
    assign wch       = wb[CH_W-1:0];
    assign sidx      = i_req.port[SP_W-1:0];
    assign chan_port = i_req.port <= LAST_CHAN_PORT;
    assign sel_word  = i_req.port[0] ? r_cur_cnt[pch] : r_cur_addr[pch];

    dmacr_xfer u_xfer (
        .i_advance_mode (i_req.command == CMD_ADVANCE),
        .i_autoinit     (r_autoinit[ch]),
        .i_cur_addr     (r_cur_addr[ch]),
        .i_cur_cnt      (r_cur_cnt[ch]),
        .i_base_addr    (r_base_addr[ch]),
        .i_base_cnt     (r_base_cnt[ch]),
        .i_adv          (i_req.advance),
        .o_res          (xres)
    );

    always_comb begin
        n_base_addr = r_base_addr;
        n_base_cnt  = r_base_cnt;
        n_cur_addr  = r_cur_addr;
        n_cur_cnt   = r_cur_cnt;
        n_page      = r_page;
        n_spare     = r_spare;
        n_autoinit  = r_autoinit;
        n_bp        = r_bp;
        n_status    = r_status;
        n_rd        = '0;
        if (go) begin
            case (t_cmd'(i_req.command))
                CMD_PORT_READ: begin
                    if (chan_port) begin
                        n_rd = r_bp ? sel_word[15:8] : sel_word[7:0];
                        n_bp = ~r_bp;
                    end else if (i_req.port == PORT_STATUS) begin
                        n_rd     = r_status;
                        n_status = r_status & STATUS_TC_KEEP;
                    end else if (is_page_port(i_req.port)) begin
                        n_rd = r_page[page_chan(i_req.port)];
                    end else if (is_spare_port(i_req.port)) begin
                        n_rd = r_spare[sidx];
                    end
                end
                CMD_PORT_WRITE: begin
                    if (chan_port) begin
                        // The low byte loads a fresh value; the high byte keeps the low byte.
                        if (i_req.port[0]) begin
                            n_base_cnt[pch] = r_bp ? {wb, r_base_cnt[pch][7:0]} : {8'h00, wb};
                            n_cur_cnt[pch]  = r_bp ? {wb, r_cur_cnt[pch][7:0]} : {8'h00, wb};
                        end else begin
                            n_base_addr[pch] = r_bp ? {wb, r_base_addr[pch][7:0]}
                                                    : {8'h00, wb};
                            n_cur_addr[pch]  = r_bp ? {wb, r_cur_addr[pch][7:0]}
                                                    : {8'h00, wb};
                        end
                        n_bp          = ~r_bp;
                        n_status[pch] = 1'b0;
                    end else begin
                        case (i_req.port)
                            PORT_CLR_REQ: begin
                                if (!wb[CLR_REQ_SKIP_BIT]) begin
                                    n_status[{1'b1, wch}] = 1'b0;
                                end
                            end
                            PORT_MODE: begin
                                n_autoinit[wch] = wb[AUTOINIT_BIT];
                                // A word access also writes the byte pointer clear port.
                                if (i_req.access_size == SIZE_WORD) begin
                                    n_bp = 1'b0;
                                end
                            end
                            PORT_CLR_BP: begin
                                n_bp = 1'b0;
                            end
                            PORT_MASTER_CLR: begin
                                n_status = '0;
                                n_bp     = 1'b0;
                            end
                            default: begin
                                if (is_page_port(i_req.port)) begin
                                    n_page[page_chan(i_req.port)] = wb;
                                end else if (is_spare_port(i_req.port)) begin
                                    n_spare[sidx] = wb;
                                end
                            end
                        endcase
                    end
                end
                CMD_STEP, CMD_ADVANCE: begin
                    n_cur_addr[ch] = xres.addr;
                    n_cur_cnt[ch]  = xres.cnt;
                    if (xres.set_tc) begin
                        n_status[ch] = 1'b1;
                    end
                end
                CMD_REQUEST: begin
                    n_status[{1'b1, ch}] = i_req.request_level;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_base_addr[i] <= '0;
                r_base_cnt[i]  <= '0;
                r_cur_addr[i]  <= '0;
                r_cur_cnt[i]   <= '0;
                r_page[i]      <= '0;
            end
            for (int i = 0; i < SPARE_DEPTH; i++) begin
                r_spare[i] <= '0;
            end
            r_autoinit  <= '0;
            r_bp        <= 1'b0;
            r_status    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_base_addr <= n_base_addr;
            r_base_cnt  <= n_base_cnt;
            r_cur_addr  <= n_cur_addr;
            r_cur_cnt   <= n_cur_cnt;
            r_page      <= n_page;
            r_spare     <= n_spare;
            r_autoinit  <= n_autoinit;
            r_bp        <= n_bp;
            r_status    <= n_status;
            if (go) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The result reflects the channel after this request's update.
    always_ff @(posedge i_clk) begin
        if (go) begin
            r_read_data      <= n_rd;
            r_full_address   <= {n_page[ch], n_cur_addr[ch]};
            r_outstanding    <= {1'b0, n_cur_cnt[ch]} + 17'd1;
            r_terminal_count <= n_status[ch];
        end
    end

    assign i_req.ready          = !r_out_valid || o_rsp.ready;
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.read_data      = r_read_data;
    assign o_rsp.full_address   = r_full_address;
    assign o_rsp.outstanding    = r_outstanding;
    assign o_rsp.terminal_count = r_terminal_count;

endmodule

/* rtl/dmacr_xfer.sv */
// Address and count update for one single-step or advance-by-count transfer.
// Depends on dmacr_pkg for the result struct and the count wrap constant.
module dmacr_xfer (
    input  logic                  i_advance_mode,
    input  logic                  i_autoinit,
    input  logic [15:0]           i_cur_addr,
    input  logic [15:0]           i_cur_cnt,
    input  logic [15:0]           i_base_addr,
    input  logic [15:0]           i_base_cnt,
    input  logic [15:0]           i_adv,
    output dmacr_pkg::t_xfer_res  o_res
);
    import dmacr_pkg::*;

    logic [15:0] addr_inc;
    logic [15:0] cnt_dec;
    logic [15:0] addr_sum;
    logic [15:0] cnt_diff;
    logic [15:0] addr_over;
    logic        under;

    assign addr_inc  = i_cur_addr + 16'd1;
    assign cnt_dec   = i_cur_cnt - 16'd1;
    assign addr_sum  = i_cur_addr + i_adv;
    assign cnt_diff  = i_cur_cnt - i_adv;
    assign under     = i_cur_cnt < i_adv;
    // Bytes left over past terminal count land in the address register.
    assign addr_over = i_adv - i_cur_cnt - 16'd1;

    always_comb begin
        if (!i_advance_mode) begin
            if (i_cur_cnt == '0) begin
                if (i_autoinit) begin
                    o_res = '{addr: i_base_addr, cnt: i_base_cnt, set_tc: 1'b0};
                end else begin
                    o_res = '{addr: addr_inc, cnt: cnt_dec, set_tc: 1'b1};
                end
            end else begin
                o_res = '{addr: addr_inc, cnt: cnt_dec, set_tc: 1'b0};
            end
        end else if (under) begin
            if (i_autoinit) begin
                o_res = '{addr: i_base_addr, cnt: i_base_cnt, set_tc: 1'b0};
            end else begin
                o_res = '{addr: addr_over, cnt: CNT_WRAP, set_tc: 1'b1};
            end
        end else begin
            o_res = '{addr: addr_sum, cnt: cnt_diff, set_tc: 1'b0};
        end
    end

endmodule

/* rtl/dmacr_checker.sv */
// Port-level checks for the DMA channel register block, bound to its top level.
// Depends on dmacr_pkg for the command codes.
module dmacr_port_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic [2:0]  i_req_command,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [7:0]  i_rsp_read_data,
    input logic [23:0] i_rsp_full_address,
    input logic [16:0] i_rsp_outstanding,
    input logic        i_rsp_terminal_count
);
    import dmacr_pkg::*;

    // A stalled result must hold.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid
            && $stable(i_rsp_full_address) && $stable(i_rsp_outstanding)
            && $stable(i_rsp_terminal_count) && $stable(i_rsp_read_data))
        else $error("stalled result changed");

    // Every accepted request produces a result on the next cycle.
    a_req_to_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> i_rsp_valid)
        else $error("accepted request without result");

    // With no result pending the block must take a new request.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rsp_valid |-> i_req_ready)
        else $error("input stalled while output empty");

    // Only port reads return data.
    a_read_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && i_req_command != CMD_PORT_READ
            |=> i_rsp_read_data == '0)
        else $error("nonzero read data on a non-read command");

    // The outstanding byte count is the current count plus one and never zero.
    a_outstanding_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_rsp_outstanding != '0)
        else $error("zero outstanding count");

endmodule

bind dma_controller_channel_registers dmacr_port_props u_dmacr_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_req_valid          (i_req.valid),
    .i_req_ready          (i_req.ready),
    .i_req_command        (i_req.command),
    .i_rsp_valid          (o_rsp.valid),
    .i_rsp_ready          (o_rsp.ready),
    .i_rsp_read_data      (o_rsp.read_data),
    .i_rsp_full_address   (o_rsp.full_address),
    .i_rsp_outstanding    (o_rsp.outstanding),
    .i_rsp_terminal_count (o_rsp.terminal_count)
);
